// ===== src/urav_pkg.sv =====
// Shared types and constants for the ultrasonic range averager.
// Used by the controller, the datapath and the divider; no dependencies.
`timescale 1ns / 1ps

package urav_pkg;

    // Register map of the configuration port
    localparam logic [1:0] CFG_MEASURE_COUNT = 2'd0;
    localparam logic [1:0] CFG_TRIGGER_TICKS = 2'd1;
    localparam logic [1:0] CFG_CM_PER_TICK   = 2'd2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Field widths
    localparam int COUNT_W = 8;
    localparam int PULSE_W = 10;
    localparam int SCALE_W = 16;
    localparam int SUM_W   = 24;
    localparam int AVG_W   = 16;
    localparam int STEP_W  = $clog2(SUM_W);

    localparam logic [SUM_W-1:0]   SUM_MAX       = {SUM_W{1'b1}};
    localparam logic [COUNT_W-1:0] MEASURE_RESET = 8'd1;
    localparam logic [PULSE_W-1:0] TRIGGER_RESET = 10'd10;
    localparam logic [SCALE_W-1:0] SCALE_RESET   = 16'd1114;

    // Sensor sequencing phase
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_TRIGGER,
        PH_WAIT_RISE,
        PH_COUNT
    } phase_t;

    // Controller states
    typedef enum logic [2:0] {
        C_IN,
        C_MUL,
        C_ACC,
        C_CHK,
        C_DIV,
        C_EMIT
    } ctrl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;     // input beat taken this cycle
        logic mul;        // register echo count times scale
        logic acc;        // add distance to sum, bump measurement count
        logic div_start;  // start the averaging divide
        logic finish;     // close the measurement and load the result beat
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic heavy;      // current beat ends a measurement
        logic last;       // measurement count reached
        logic div_done;   // quotient ready
        logic slot_free;  // output register can take a beat
    } dp_stat_t;

endpackage

// ===== src/urav_div.sv =====
// Restoring divider, one quotient bit per cycle, for the run average.
// Depends on urav_pkg for widths.
`timescale 1ns / 1ps

module urav_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [urav_pkg::SUM_W-1:0]    dividend,
    input  logic [urav_pkg::COUNT_W-1:0]  divisor,
    output logic [urav_pkg::SUM_W-1:0]    quotient,
    output logic                          done
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [urav_pkg::STEP_W-1:0]   step_reg, step_next;
    logic [urav_pkg::COUNT_W-1:0]  rem_reg, rem_next;
    logic [urav_pkg::SUM_W-1:0]    quo_reg, quo_next;
    logic [urav_pkg::COUNT_W-1:0]  div_reg, div_next;
    logic [urav_pkg::COUNT_W:0]    trial;

    // One shift-subtract step per cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        trial     = {rem_reg, quo_reg[urav_pkg::SUM_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            step_next = '0;
            rem_next  = '0;
            quo_next  = dividend;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = urav_pkg::COUNT_W'(trial - {1'b0, div_reg});
                quo_next = {quo_reg[urav_pkg::SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[urav_pkg::COUNT_W-1:0];
                quo_next = {quo_reg[urav_pkg::SUM_W-2:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == urav_pkg::STEP_W'(urav_pkg::SUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// ===== src/urav_dp.sv =====
// Datapath: configuration registers, sensor sequencing state, scale multiply,
// saturating sum, divider and the output beat register. Uses urav_pkg, urav_div.
`timescale 1ns / 1ps

module urav_dp
#(
    parameter int ECHO_COUNT_BITS = 20
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [urav_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [urav_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              start_req,
    input  logic                              echo_level,
    input  urav_pkg::ctrl_cmd_t               cmd,
    output urav_pkg::dp_stat_t                stat,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic                              trigger_level,
    output logic                              busy_res,
    output logic                              result_valid,
    output logic [urav_pkg::AVG_W-1:0]        average_cm
);

    localparam int EB     = ECHO_COUNT_BITS;
    localparam int PROD_W = EB + urav_pkg::SCALE_W;
    localparam int ADD_W  = ((EB > urav_pkg::SUM_W) ? EB : urav_pkg::SUM_W) + 1;

    logic [urav_pkg::COUNT_W-1:0] meas_count_reg;
    logic [urav_pkg::PULSE_W-1:0] trig_ticks_reg;
    logic [urav_pkg::SCALE_W-1:0] scale_reg;

    urav_pkg::phase_t             phase_reg, phase_next;
    logic [urav_pkg::PULSE_W-1:0] pulse_reg, pulse_next;
    logic [EB-1:0]                echo_cnt_reg, echo_cnt_next;
    logic [urav_pkg::COUNT_W-1:0] done_reg, done_next;
    logic [urav_pkg::SUM_W-1:0]   sum_reg, sum_next;
    logic                         prev_echo_reg, prev_echo_next;
    logic [urav_pkg::AVG_W-1:0]   last_avg_reg, last_avg_next;
    logic [PROD_W-1:0]            product_reg;

    logic                         out_valid_reg, out_valid_next;
    logic                         out_trig_reg, out_trig_next;
    logic                         out_busy_reg, out_busy_next;
    logic                         out_rv_reg, out_rv_next;
    logic [urav_pkg::AVG_W-1:0]   out_avg_reg, out_avg_next;
    logic                         out_load;

    logic [urav_pkg::COUNT_W-1:0] eff_count;
    logic [urav_pkg::PULSE_W-1:0] eff_trigger;
    logic [EB-1:0]                dist_cm;
    logic [ADD_W-1:0]             sum_wide;
    logic [urav_pkg::SUM_W-1:0]   quotient;
    logic                         div_done;
    logic [urav_pkg::AVG_W-1:0]   avg_sat;
    logic                         heavy;
    logic                         last;
    logic                         slot_free;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            meas_count_reg <= urav_pkg::MEASURE_RESET;
            trig_ticks_reg <= urav_pkg::TRIGGER_RESET;
            scale_reg      <= urav_pkg::SCALE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                urav_pkg::CFG_MEASURE_COUNT:
                    meas_count_reg <= cfg_data[urav_pkg::COUNT_W-1:0];
                urav_pkg::CFG_TRIGGER_TICKS:
                    trig_ticks_reg <= cfg_data[urav_pkg::PULSE_W-1:0];
                urav_pkg::CFG_CM_PER_TICK:
                    scale_reg <= cfg_data[urav_pkg::SCALE_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // Zero counts behave as one
    assign eff_count   = (meas_count_reg == '0) ? urav_pkg::COUNT_W'(1) : meas_count_reg;
    assign eff_trigger = (trig_ticks_reg == '0) ? urav_pkg::PULSE_W'(1) : trig_ticks_reg;

    // Distance and saturating sum
    assign dist_cm  = product_reg[PROD_W-1:urav_pkg::SCALE_W];
    assign sum_wide = ADD_W'(sum_reg) + ADD_W'(dist_cm);
    assign avg_sat  = (quotient[urav_pkg::SUM_W-1:urav_pkg::AVG_W] != '0)
                      ? {urav_pkg::AVG_W{1'b1}} : quotient[urav_pkg::AVG_W-1:0];

    assign heavy     = (phase_reg == urav_pkg::PH_COUNT) && !echo_level;
    assign last      = (done_reg >= eff_count);
    assign slot_free = !out_valid_reg || out_ready;

    urav_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (sum_reg),
        .divisor  (eff_count),
        .quotient (quotient),
        .done     (div_done)
    );

    // State update and result beat
    always_comb
    begin
        phase_next     = phase_reg;
        pulse_next     = pulse_reg;
        echo_cnt_next  = echo_cnt_reg;
        done_next      = done_reg;
        sum_next       = sum_reg;
        prev_echo_next = prev_echo_reg;
        last_avg_next  = last_avg_reg;
        out_load       = 1'b0;
        out_trig_next  = out_trig_reg;
        out_busy_next  = out_busy_reg;
        out_rv_next    = out_rv_reg;
        out_avg_next   = out_avg_reg;

        if (cmd.accept)
        begin
            prev_echo_next = echo_level;
            out_trig_next  = 1'b0;
            case (phase_reg)
                urav_pkg::PH_IDLE:
                begin
                    if (start_req)
                    begin
                        done_next     = '0;
                        sum_next      = '0;
                        pulse_next    = urav_pkg::PULSE_W'(1);
                        phase_next    = urav_pkg::PH_TRIGGER;
                        out_trig_next = 1'b1;
                    end
                end
                urav_pkg::PH_TRIGGER:
                begin
                    if (pulse_reg >= eff_trigger)
                    begin
                        phase_next = urav_pkg::PH_WAIT_RISE;
                    end
                    else
                    begin
                        pulse_next    = pulse_reg + 1'b1;
                        out_trig_next = 1'b1;
                    end
                end
                urav_pkg::PH_WAIT_RISE:
                begin
                    if (echo_level && !prev_echo_reg)
                    begin
                        echo_cnt_next = EB'(1);
                        phase_next    = urav_pkg::PH_COUNT;
                    end
                end
                urav_pkg::PH_COUNT:
                begin
                    // Falling edge is finished by the controller sequence
                    if (echo_level && (echo_cnt_reg != {EB{1'b1}}))
                    begin
                        echo_cnt_next = echo_cnt_reg + 1'b1;
                    end
                end
                default:
                    ;
            endcase
            if (!heavy)
            begin
                out_load      = 1'b1;
                out_busy_next = (phase_next != urav_pkg::PH_IDLE);
                out_rv_next   = 1'b0;
                out_avg_next  = last_avg_reg;
            end
        end

        if (cmd.acc)
        begin
            sum_next  = (sum_wide > ADD_W'(urav_pkg::SUM_MAX))
                        ? urav_pkg::SUM_MAX : sum_wide[urav_pkg::SUM_W-1:0];
            done_next = done_reg + 1'b1;
        end

        if (cmd.finish)
        begin
            out_load = 1'b1;
            if (last)
            begin
                last_avg_next = avg_sat;
                phase_next    = urav_pkg::PH_IDLE;
                out_trig_next = 1'b0;
                out_busy_next = 1'b0;
                out_rv_next   = 1'b1;
                out_avg_next  = avg_sat;
            end
            else
            begin
                pulse_next    = urav_pkg::PULSE_W'(1);
                phase_next    = urav_pkg::PH_TRIGGER;
                out_trig_next = 1'b1;
                out_busy_next = 1'b1;
                out_rv_next   = 1'b0;
                out_avg_next  = last_avg_reg;
            end
        end

        out_valid_next = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= urav_pkg::PH_IDLE;
            pulse_reg     <= '0;
            echo_cnt_reg  <= '0;
            done_reg      <= '0;
            sum_reg       <= '0;
            prev_echo_reg <= 1'b0;
            last_avg_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            pulse_reg     <= pulse_next;
            echo_cnt_reg  <= echo_cnt_next;
            done_reg      <= done_next;
            sum_reg       <= sum_next;
            prev_echo_reg <= prev_echo_next;
            last_avg_reg  <= last_avg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            product_reg <= PROD_W'(echo_cnt_reg) * PROD_W'(scale_reg);
        end
        out_trig_reg <= out_trig_next;
        out_busy_reg <= out_busy_next;
        out_rv_reg   <= out_rv_next;
        out_avg_reg  <= out_avg_next;
    end

    assign stat.heavy     = heavy;
    assign stat.last      = last;
    assign stat.div_done  = div_done;
    assign stat.slot_free = slot_free;

    assign out_valid     = out_valid_reg;
    assign trigger_level = out_trig_reg;
    assign busy_res      = out_busy_reg;
    assign result_valid  = out_rv_reg;
    assign average_cm    = out_avg_reg;

endmodule

// ===== src/urav_ctrl.sv =====
// Controller state machine: takes input beats and sequences the multiply,
// accumulate, divide and result steps of the datapath. Uses urav_pkg.
`timescale 1ns / 1ps

module urav_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  urav_pkg::dp_stat_t     stat,
    output urav_pkg::ctrl_cmd_t    cmd
);

    urav_pkg::ctrl_state_t state_reg, state_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            urav_pkg::C_IN:
            begin
                if (in_valid && stat.slot_free && stat.heavy)
                begin
                    state_next = urav_pkg::C_MUL;
                end
            end
            urav_pkg::C_MUL:
                state_next = urav_pkg::C_ACC;
            urav_pkg::C_ACC:
                state_next = urav_pkg::C_CHK;
            urav_pkg::C_CHK:
                state_next = stat.last ? urav_pkg::C_DIV : urav_pkg::C_EMIT;
            urav_pkg::C_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = urav_pkg::C_EMIT;
                end
            end
            urav_pkg::C_EMIT:
            begin
                if (stat.slot_free)
                begin
                    state_next = urav_pkg::C_IN;
                end
            end
            default:
                state_next = urav_pkg::C_IN;
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready      = 1'b0;
        cmd           = '0;
        case (state_reg)
            urav_pkg::C_IN:
            begin
                in_ready   = stat.slot_free;
                cmd.accept = in_valid && stat.slot_free;
            end
            urav_pkg::C_MUL:
                cmd.mul = 1'b1;
            urav_pkg::C_ACC:
                cmd.acc = 1'b1;
            urav_pkg::C_CHK:
                cmd.div_start = stat.last;
            urav_pkg::C_DIV:
                ;
            urav_pkg::C_EMIT:
                cmd.finish = stat.slot_free;
            default:
                ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= urav_pkg::C_IN;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef NO_ASSERTIONS
    // A measurement-ending beat always starts the multiply next
    a_heavy_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && stat.heavy) |=> (state_reg == urav_pkg::C_MUL))
        else $error("ending beat did not start multiply");

    // The divider runs only after the count check
    a_div_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == urav_pkg::C_DIV) |->
        ($past(state_reg) == urav_pkg::C_CHK || $past(state_reg) == urav_pkg::C_DIV))
        else $error("divide entered out of sequence");

    // At most one datapath command per cycle
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("overlapping datapath commands");

    // No input beat is taken while a measurement is being closed
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != urav_pkg::C_IN) |-> !in_ready)
        else $error("input taken during closing sequence");
`endif

endmodule

// ===== src/ultrasonic_range_averager.sv =====
// Ultrasonic ranging controller with run averaging: one timebase tick per
// input beat, one status beat per tick. An ordinary tick needs only the
// accept step; a tick on which the echo falls passes through accept, scale
// multiply, saturating accumulate, count check and result load, and the last
// measurement of a run adds the bit-serial divide that forms the average (one
// quotient bit per clock over the 24-bit sum, then the done flag).
// A status beat waiting in the output register holds off the next tick; that
// tick is taken at the earliest in the cycle the waiting beat leaves.
// Depends on urav_pkg, urav_ctrl, urav_dp, urav_div.
`timescale 1ns / 1ps

module ultrasonic_range_averager
#(
    parameter int ECHO_COUNT_BITS = 20
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration write port
    input  logic                              cfg_we,
    input  logic [urav_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [urav_pkg::CFG_DATA_W-1:0]   cfg_data,
    // Tick input
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,  // [0] start_req, [1] echo_level
    // Status output
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [23:0]                       m_tdata   // [0] trigger_level, [1] busy_res,
                                                        // [2] result_valid, [18:3] average_cm
);

    urav_pkg::ctrl_cmd_t         cmd;
    urav_pkg::dp_stat_t          stat;
    logic                        trigger_level;
    logic                        busy_res;
    logic                        result_valid;
    logic [urav_pkg::AVG_W-1:0]  average_cm;

    urav_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    urav_dp #(
        .ECHO_COUNT_BITS (ECHO_COUNT_BITS)
    ) u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .start_req     (s_tdata[0]),
        .echo_level    (s_tdata[1]),
        .cmd           (cmd),
        .stat          (stat),
        .out_ready     (m_tready),
        .out_valid     (m_tvalid),
        .trigger_level (trigger_level),
        .busy_res      (busy_res),
        .result_valid  (result_valid),
        .average_cm    (average_cm)
    );

    assign m_tdata = {5'b0, average_cm, result_valid, busy_res, trigger_level};

endmodule

// ===== dv/ultrasonic_range_averager_checker.sv =====
// Status-beat checker for the ultrasonic range averager: follows register writes
// and accepted tick beats, predicts each status beat and compares it on the way out.
// Depends on urav_pkg.
`timescale 1ns / 1ps

module ultrasonic_range_averager_checker
    import urav_pkg::*;
#(
    parameter int ECHO_BITS = 20
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [0] start_req, [1] echo_level
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [23:0]           m_tdata,   // [0] trigger_level, [1] busy_res,
                                             // [2] result_valid, [18:3] average_cm
    output int                    mismatches,
    output int                    pending
);

    typedef struct packed {
        logic             trigger;
        logic             busy;
        logic             done;
        logic [AVG_W-1:0] average;
    } status_t;

    // Shadow registers
    logic [COUNT_W-1:0]   runs_cfg;
    logic [PULSE_W-1:0]   trig_cfg;
    logic [SCALE_W-1:0]   scale_cfg;

    // Shadow sequencer state
    phase_t               ph;
    logic [PULSE_W-1:0]   pulse_cnt;
    logic [ECHO_BITS-1:0] echo_cnt;
    logic [COUNT_W-1:0]   runs_done;
    logic [SUM_W-1:0]     dist_sum;
    logic                 echo_prev;
    logic [AVG_W-1:0]     avg_hold;

    status_t              status_q[$];

    // One timebase tick of the ranging sequencer; returns the status it shows after
    task automatic advance_tick(input logic start, input logic echo, output status_t st);
        logic [COUNT_W-1:0] runs_eff;
        logic [PULSE_W-1:0] trig_eff;
        logic [63:0]        dist_cm;
        logic [64:0]        sum;
        logic [SUM_W-1:0]   avg;
        runs_eff = (runs_cfg == '0) ? COUNT_W'(1) : runs_cfg;
        trig_eff = (trig_cfg == '0) ? PULSE_W'(1) : trig_cfg;
        st = '0;
        case (ph)
            PH_IDLE:
            begin
                if (start)
                begin
                    runs_done = '0;
                    dist_sum  = '0;
                    pulse_cnt = PULSE_W'(1);
                    ph        = PH_TRIGGER;
                    st.trigger = 1'b1;
                end
            end
            PH_TRIGGER:
            begin
                if (pulse_cnt >= trig_eff)
                    ph = PH_WAIT_RISE;
                else
                begin
                    pulse_cnt  = pulse_cnt + 1'b1;
                    st.trigger = 1'b1;
                end
            end
            PH_WAIT_RISE:
            begin
                // level already high on entry is not an edge
                if (echo && !echo_prev)
                begin
                    echo_cnt = ECHO_BITS'(1);
                    ph       = PH_COUNT;
                end
            end
            default:
            begin
                if (echo)
                begin
                    if (echo_cnt != '1)
                        echo_cnt = echo_cnt + 1'b1;
                end
                else
                begin
                    // falling edge: scale, accumulate with saturation
                    dist_cm   = (64'(echo_cnt) * 64'(scale_cfg)) >> 16;
                    sum       = 65'(dist_sum) + 65'(dist_cm);
                    dist_sum  = (sum > 65'(SUM_MAX)) ? SUM_MAX : sum[SUM_W-1:0];
                    runs_done = runs_done + 1'b1;
                    if (runs_done >= runs_eff)
                    begin
                        avg      = dist_sum / SUM_W'(runs_eff);
                        avg_hold = (|avg[SUM_W-1:AVG_W]) ? '1 : avg[AVG_W-1:0];
                        st.done  = 1'b1;
                        ph       = PH_IDLE;
                    end
                    else
                    begin
                        pulse_cnt  = PULSE_W'(1);
                        ph         = PH_TRIGGER;
                        st.trigger = 1'b1;
                    end
                end
            end
        endcase
        echo_prev  = echo;
        st.busy    = (ph != PH_IDLE);
        st.average = avg_hold;
    endtask

    task automatic note_fault(input string what, input status_t want, input status_t got);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("%0t: %s", $realtime, what);
            $display("  expected trigger %0b busy %0b done %0b average %0d",
                     want.trigger, want.busy, want.done, want.average);
            $display("  actual   trigger %0b busy %0b done %0b average %0d",
                     got.trigger, got.busy, got.done, got.average);
        end
    endtask

    // Watch all channels; outgoing beat is retired before a new tick is predicted
    always @(posedge clk or negedge rst_n)
    begin : watch
        status_t want;
        status_t got;
        if (!rst_n)
        begin
            runs_cfg   = MEASURE_RESET;
            trig_cfg   = TRIGGER_RESET;
            scale_cfg  = SCALE_RESET;
            ph         = PH_IDLE;
            pulse_cnt  = '0;
            echo_cnt   = '0;
            runs_done  = '0;
            dist_sum   = '0;
            echo_prev  = 1'b0;
            avg_hold   = '0;
            mismatches = 0;
            pending    = 0;
            status_q.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.trigger = m_tdata[0];
                got.busy    = m_tdata[1];
                got.done    = m_tdata[2];
                got.average = m_tdata[18:3];
                if (status_q.size() == 0)
                    note_fault("status beat with none expected", '0, got);
                else
                begin
                    want = status_q.pop_front();
                    if (got.trigger !== want.trigger || got.busy !== want.busy ||
                        got.done !== want.done || got.average !== want.average)
                        note_fault("status beat mismatch", want, got);
                end
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MEASURE_COUNT: runs_cfg  = cfg_data[COUNT_W-1:0];
                    CFG_TRIGGER_TICKS: trig_cfg  = cfg_data[PULSE_W-1:0];
                    CFG_CM_PER_TICK:   scale_cfg = cfg_data[SCALE_W-1:0];
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready)
            begin
                advance_tick(s_tdata[0], s_tdata[1], want);
                status_q.push_back(want);
            end
            pending = status_q.size();
        end
    end

endmodule

// ===== dv/ultrasonic_range_averager_test.sv =====
// Top of the range averager testbench: clock, reset, tick stimulus, output
// back-pressure, watchdog and verdict. Depends on urav_pkg, the block and
// ultrasonic_range_averager_checker.
`timescale 1ns / 1ps

module ultrasonic_range_averager_test;
    import urav_pkg::*;

    // Echo counter width for the block under test
    localparam int ECHO_BITS   = 12;
    localparam int QUIET_LIMIT = 5000;
    localparam int PHASE_TICKS = 100;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;   // [0] start_req, [1] echo_level
    logic                  m_tvalid;
    logic                  m_tready;
    logic [23:0]           m_tdata;   // [0] trigger_level, [1] busy_res,
                                      // [2] result_valid, [18:3] average_cm
    int                    mismatches;
    int                    pending;

    int                    burst_left = 0;
    int                    ticks_sent = 0;
    int                    trig_now   = 10;
    int                    runs_now   = 1;
    int                    sink_cycle = 0;
    int                    sink_mode  = 0;
    int                    hold_left  = 0;
    int                    hold_asks  = 0;
    int                    hold_seen  = 0;

    always #10 clk = ~clk;

    ultrasonic_range_averager #(.ECHO_COUNT_BITS(ECHO_BITS)) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    ultrasonic_range_averager_checker #(.ECHO_BITS(ECHO_BITS)) status_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // Status sink: changing stall pattern, plus a long hold-off when asked
    always @(posedge clk)
    begin
        sink_cycle++;
        if (hold_asks != hold_seen)
        begin
            hold_seen = hold_asks;
            hold_left = 300;
        end
        if (sink_cycle % 512 == 0)
            sink_mode = $urandom_range(0, 3);
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            case (sink_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= (sink_cycle % 3 == 0);
                default: m_tready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // Watchdog on cycles with no beat moving on either side
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // One tick beat, sent in bursts with random gaps
    task automatic send_tick(input logic start, input logic echo);
        int gap;
        if (burst_left <= 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 20);
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, echo, start};
        do @(posedge clk); while (!s_tready);
        burst_left--;
        ticks_sent++;
    endtask

    // Stop sending and wait for every status beat to come back
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (40) @(posedge clk);
    endtask

    task automatic set_config(input int runs, input int trig, input int scale);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MEASURE_COUNT;
        cfg_data  <= CFG_DATA_W'(runs);
        @(posedge clk);
        cfg_index <= CFG_TRIGGER_TICKS;
        cfg_data  <= CFG_DATA_W'(trig);
        @(posedge clk);
        cfg_index <= CFG_CM_PER_TICK;
        cfg_data  <= CFG_DATA_W'(scale);
        @(posedge clk);
        cfg_we    <= 1'b0;
        runs_now = (runs == 0) ? 1 : runs;
        trig_now = (trig == 0) ? 1 : trig;
    endtask

    function automatic logic stray_start();
        return ($urandom_range(0, 7) == 0);
    endfunction

    // Well-formed run with random content; sometimes cut short
    task automatic random_run();
        int meas;
        int hi;
        meas = ($urandom_range(0, 9) == 0) ? $urandom_range(0, runs_now) : runs_now;
        send_tick(1'b1, 1'($urandom_range(0, 1)));
        for (int i = 0; i < meas; i++)
        begin
            // echo noise under the trigger pulse is ignored
            repeat (trig_now) send_tick(stray_start(), 1'($urandom_range(0, 1)));
            repeat ($urandom_range(1, 4)) send_tick(stray_start(), 1'b0);
            hi = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400)
                                             : $urandom_range(1, 30);
            repeat (hi) send_tick(stray_start(), 1'b1);
            send_tick(stray_start(), 1'b0);
        end
    endtask

    initial
    begin : stimulus
        int phase_base;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_MEASURE_COUNT;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings; echo while idle, start while busy, echo high into the wait
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);
        repeat (10) send_tick(1'b1, 1'b1);
        repeat (2) send_tick(1'b0, 1'b0);
        repeat (40) send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        drain();

        // Zero count, zero trigger length, zero scale
        set_config(0, 0, 0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        repeat (4) send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        drain();

        // Largest count, shortest trigger, full scale; then the count drops below
        // the measurements already done
        set_config(255, 1, 65535);
        send_tick(1'b1, 1'b0);
        repeat (5)
        begin
            send_tick(1'b0, 1'b0);
            repeat ($urandom_range(1, 2)) send_tick(1'b0, 1'b1);
            send_tick(1'b0, 1'b0);
        end
        drain();
        set_config(3, 1, 65535);
        send_tick(1'b0, 1'b0);
        repeat ($urandom_range(1, 2)) send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        drain();

        // Count lowered in mid-run: ends at the next finished measurement
        set_config(6, 3, 1114);
        send_tick(1'b1, 1'b0);
        repeat (2)
        begin
            repeat (3) send_tick(1'b0, 1'b0);
            repeat (40) send_tick(1'b0, 1'b1);
            send_tick(1'b0, 1'b0);
        end
        drain();
        set_config(1, 3, 40000);
        repeat (3) send_tick(1'b0, 1'b0);
        repeat (40) send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        drain();

        // Longest trigger pulse, smallest nonzero scale; the sink holds off meanwhile
        set_config(1, 1023, 1);
        send_tick(1'b1, 1'b0);
        hold_asks++;
        repeat (1024) send_tick(1'b0, 1'b0);
        repeat (7) send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        drain();

        // Random phases, each under its own settings
        repeat (5)
        begin
            case ($urandom_range(0, 4))
                0:       runs_now = 1;
                1:       runs_now = 0;
                default: runs_now = $urandom_range(1, 4);
            endcase
            trig_now = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 12);
            case ($urandom_range(0, 5))
                0:       set_config(runs_now, trig_now, 0);
                1:       set_config(runs_now, trig_now, 1);
                2:       set_config(runs_now, trig_now, 65535);
                default: set_config(runs_now, trig_now, $urandom_range(1, 65535));
            endcase
            phase_base = ticks_sent;
            while (ticks_sent - phase_base < PHASE_TICKS)
            begin
                if ($urandom_range(0, 99) < 85)
                    random_run();
                else
                    repeat ($urandom_range(1, 10))
                        send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
            drain();
        end

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
